FILE: rtl/ddp_pkg.sv
// Shared types and constants for the DDP pixel packet deframer.
// No dependencies; imported by every module of the block.
package ddp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Header byte positions.
  localparam logic [10:0] POS_FLAGS    = 11'd0;
  localparam logic [10:0] POS_TYPE     = 11'd2;
  localparam logic [10:0] POS_OFS_HI   = 11'd4;
  localparam logic [10:0] POS_OFS_LO   = 11'd7;
  localparam logic [10:0] POS_DLEN_HI  = 11'd8;
  localparam logic [10:0] POS_DLEN_LO  = 11'd9;
  localparam logic [10:0] HDR_LEN      = 11'd10;
  localparam logic [10:0] HDR_TC_LEN   = 11'd14;
  localparam logic [10:0] POS_MAX      = 11'd2047;
  localparam logic [10:0] MIN_PACKET   = 11'd5;
  localparam logic [4:0]  TIMECODE_LEN = 5'd4;

  // Header flag bits and masks.
  localparam logic [7:0] VER_MASK  = 8'hc0;
  localparam logic [7:0] VER_ONE   = 8'h40;
  localparam int         FLAG_QUERY = 1;
  localparam int         FLAG_TC    = 4;
  localparam int         FLAG_PUSH  = 0;

  // Data type codes that mean four bytes per LED.
  localparam logic [7:0] TYPE_MASK   = 8'h38;
  localparam logic [7:0] TYPE_RGBW_A = 8'h18;
  localparam logic [7:0] TYPE_RGBW_B = 8'h03;

  // Reciprocal of three for ten-bit digits: q = (v * 683) >> 11.
  localparam logic [9:0] RECIP3 = 10'd683;

  // Results caused by one input byte: an optional pixel then an optional trailer.
  typedef struct packed {
    logic        pix_v;
    logic        trl_v;
    logic [1:0]  trl_kind;
    logic [11:0] led_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
    logic        has_white;
  } bundle_t;

endpackage

FILE: rtl/ddp_parse.sv
// Per-byte header capture, packet checks and pixel assembly.
// Depends on ddp_pkg; flags a bundle_t with bundle_valid for each accepted byte that yields a result.
module ddp_parse import ddp_pkg::*; #(
  parameter int MAX_PACKET = 1500,
  parameter int MAX_LEDS   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic [10:0] packet_length,
  input  logic        last_byte,
  input  logic [12:0] led_count,
  output logic        bundle_valid,
  output bundle_t     bundle
);

  localparam logic [10:0] MaxPacket = 11'(MAX_PACKET);
  localparam logic [16:0] MaxLeds   = 17'(MAX_LEDS);

  logic [10:0] pos, pos_next;
  logic [7:0]  flags, flags_next;
  logic [7:0]  dtype, dtype_next;
  logic [31:0] offset, offset_next;
  logic [31:0] q3, q3_next;
  logic [1:0]  rem3, rem3_next;
  logic [15:0] dlen, dlen_next;
  logic [7:0]  pb0, pb1, pb2;
  logic [7:0]  pb0_next, pb1_next, pb2_next;
  logic [1:0]  bip, bip_next;
  logic [12:0] led_pos, led_pos_next;
  logic        dropped, dropped_next;

  logic        bpl4;
  logic [16:0] count;
  logic [9:0]  digit;
  logic [19:0] digit_prod;
  logic [7:0]  qd;
  logic [9:0]  qd_x3;
  logic [31:0] quot;
  logic [16:0] expected;
  logic [10:0] start;
  logic        drop_len;
  logic        emit_pix;
  bundle_t     b_next;

  assign bpl4  = ((dtype & TYPE_MASK) == TYPE_RGBW_A) || (dtype == TYPE_RGBW_B);
  assign count = ({4'd0, led_count} < MaxLeds) ? {4'd0, led_count} : MaxLeds;

  // Long division of the channel offset by three, one byte per step.
  assign digit      = {rem3, data_byte};
  assign digit_prod = digit * RECIP3;
  assign qd         = digit_prod[18:11];
  assign qd_x3      = {2'd0, qd} + {1'b0, qd, 1'b0};

  assign start    = flags[FLAG_TC] ? HDR_TC_LEN : HDR_LEN;
  assign drop_len = (packet_length < MIN_PACKET) || (packet_length > MaxPacket);

  always_comb begin
    pos_next     = pos;
    flags_next   = flags;
    dtype_next   = dtype;
    offset_next  = offset;
    q3_next      = q3;
    rem3_next    = rem3;
    dlen_next    = dlen;
    pb0_next     = pb0;
    pb1_next     = pb1;
    pb2_next     = pb2;
    bip_next     = bip;
    led_pos_next = led_pos;
    dropped_next = dropped | drop_len;
    emit_pix     = 1'b0;
    expected     = '0;
    quot         = bpl4 ? {2'd0, offset[31:2]} : q3;
    b_next       = '0;

    if (pos < HDR_LEN) begin
      case (pos) inside
        POS_FLAGS: begin
          flags_next = data_byte;
          if ((data_byte & VER_MASK) != VER_ONE) begin
            dropped_next = 1'b1;
          end
        end
        POS_TYPE: begin
          dtype_next = data_byte;
        end
        [POS_OFS_HI:POS_OFS_LO]: begin
          offset_next = {offset[23:0], data_byte};
          q3_next     = {q3[23:0], qd};
          rem3_next   = 2'(digit - qd_x3);
        end
        POS_DLEN_HI: begin
          dlen_next = {8'd0, data_byte};
        end
        POS_DLEN_LO: begin
          dlen_next = {dlen[7:0], data_byte};
          if (!flags[FLAG_QUERY]) begin
            expected = 17'(HDR_LEN) + {1'b0, dlen_next}
                     + (flags[FLAG_TC] ? 17'(TIMECODE_LEN) : 17'd0);
            if ({6'd0, packet_length} < expected) begin
              dropped_next = 1'b1;
            end
            // Saturate: anything at or past the top of the 13-bit range never writes.
            led_pos_next = (quot[31:13] != '0) ? '1 : quot[12:0];
            bip_next     = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (!dropped_next && !flags[FLAG_QUERY] && (pos < packet_length)
                 && (pos >= start)) begin
      if ((bpl4 && bip == 2'd3) || (!bpl4 && bip == 2'd2)) begin
        bip_next = '0;
        if ({4'd0, led_pos} < count) begin
          emit_pix       = 1'b1;
          led_pos_next   = led_pos + 13'd1;
          b_next.pix_v   = 1'b1;
          b_next.led_index = led_pos[11:0];
          b_next.red     = pb0;
          if (bpl4) begin
            b_next.green     = pb1;
            b_next.blue      = pb2;
            b_next.white     = data_byte;
            b_next.has_white = 1'b1;
          end else begin
            b_next.green = pb1;
            b_next.blue  = data_byte;
          end
        end
      end else begin
        case (bip)
          2'd0:    pb0_next = data_byte;
          2'd1:    pb1_next = data_byte;
          default: pb2_next = data_byte;
        endcase
        bip_next = bip + 2'd1;
      end
    end

    if (last_byte) begin
      if (!dropped_next) begin
        if (flags_next[FLAG_QUERY]) begin
          b_next.trl_v    = 1'b1;
          b_next.trl_kind = KIND_QUERY;
        end else if ((pos >= POS_DLEN_LO) && flags_next[FLAG_PUSH]) begin
          b_next.trl_v    = 1'b1;
          b_next.trl_kind = KIND_PUSH;
        end
      end
      pos_next     = '0;
      flags_next   = '0;
      dtype_next   = '0;
      offset_next  = '0;
      q3_next      = '0;
      rem3_next    = '0;
      dlen_next    = '0;
      bip_next     = '0;
      led_pos_next = '0;
      dropped_next = 1'b0;
    end else if (pos != POS_MAX) begin
      pos_next = pos + 11'd1;
    end
  end

  assign bundle_valid = take && (emit_pix || b_next.trl_v);
  assign bundle       = b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      flags   <= '0;
      dtype   <= '0;
      offset  <= '0;
      q3      <= '0;
      rem3    <= '0;
      dlen    <= '0;
      bip     <= '0;
      led_pos <= '0;
      dropped <= 1'b0;
    end else if (take) begin
      pos     <= pos_next;
      flags   <= flags_next;
      dtype   <= dtype_next;
      offset  <= offset_next;
      q3      <= q3_next;
      rem3    <= rem3_next;
      dlen    <= dlen_next;
      bip     <= bip_next;
      led_pos <= led_pos_next;
      dropped <= dropped_next;
    end
  end

  // Pixel byte holding registers are always written before use in a packet.
  always_ff @(posedge clk) begin
    if (take) begin
      pb0 <= pb0_next;
      pb1 <= pb1_next;
      pb2 <= pb2_next;
    end
  end

endmodule

FILE: rtl/ddp_outq.sv
// Two-entry result queue and serializer onto the master stream.
// Depends on ddp_pkg; each entry holds the results of one input byte.
module ddp_outq import ddp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  bundle_t     push_data,
  output logic        space,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  bundle_t    entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       pix_sent;
  bundle_t    head;
  logic       show_pix;
  logic       xfer;
  logic       pop;

  assign head     = entry[rd_ptr];
  assign show_pix = head.pix_v && !pix_sent;
  assign space    = (fill != 2'd2);
  assign m_tvalid = (fill != 2'd0);
  assign m_tlast  = !show_pix || !head.trl_v;
  assign xfer     = m_tvalid && m_tready;
  assign pop      = xfer && m_tlast;

  always_comb begin
    if (show_pix) begin
      m_tdata = {4'd0, head.white, head.blue, head.green, head.red, head.led_index};
      m_tuser = {head.has_white, KIND_PIXEL};
    end else begin
      m_tdata = '0;
      m_tuser = {1'b0, head.trl_kind};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fill     <= '0;
      pix_sent <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr   <= !rd_ptr;
        pix_sent <= 1'b0;
      end else if (xfer) begin
        pix_sent <= 1'b1;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/ddp_pixel_packet_deframer.sv
// Top level of the DDP pixel packet deframer.
// Depends on ddp_pkg, ddp_parse and ddp_outq.
//
// Usage:
//   Slave stream: one datagram payload byte per transaction, with the
//   datagram's total length beside it and tlast on its final byte.
//   Master stream: pixel writes (kind 0), render pushes (kind 1) and query
//   notices (kind 2); tlast marks the final result caused by one input byte.
//   cfg_wr_en/cfg_wr_data set the attached LED count; write it while idle.
// Output: each result is registered in the result queue before it appears
//   on the master side.
// Throughput: one input byte per cycle while s_tready is high. A byte that
//   finishes a pixel and also carries a render push yields two results,
//   which the master side sends as two transfers, pixel first.
// Stall: a two-entry result queue sits between the parser and the master
//   side, so the parser keeps taking bytes while a result waits; s_tready
//   drops only when both entries are full.
// Reset: rst clears the parser state, the queue and the LED count (zero, so
//   no pixel is written until the count is set).
module ddp_pixel_packet_deframer import ddp_pkg::*; #(
  parameter int MAX_PACKET = 1500,
  parameter int MAX_LEDS   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,     // [7:0] data_byte, [18:8] packet_length, rest zero
  input  logic        s_tlast,     // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,     // led_index[11:0], red, green, blue, white, zero pad
  output logic [2:0]  m_tuser,     // kind[1:0], has_white
  output logic        m_tlast,     // last_of_item
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data  // led_count
);

  logic [12:0] led_count;
  logic        take;
  logic        bundle_valid;
  bundle_t     bundle;

  // Hold the LED count; the user must write it only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= '0;
    end else if (cfg_wr_en) begin
      led_count <= cfg_wr_data;
    end
  end

  assign take = s_tvalid && s_tready;

  ddp_parse #(
    .MAX_PACKET(MAX_PACKET),
    .MAX_LEDS  (MAX_LEDS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .data_byte    (s_tdata[7:0]),
    .packet_length(s_tdata[18:8]),
    .last_byte    (s_tlast),
    .led_count    (led_count),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  // Queue the results of each byte; advance the input whenever a slot is free.
  ddp_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (bundle_valid),
    .push_data(bundle),
    .space    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
